// ----- src/lec_pkg.sv -----
package lec_pkg;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // newline_mode codes; the spare code behaves as CR LF
  localparam logic [1:0] ModeCrLf = 2'd0;
  localparam logic [1:0] ModeLf   = 2'd1;
  localparam logic [1:0] ModeCr   = 2'd2;

  // classified request: line endings to emit, then an optional data byte
  typedef struct packed {
    logic [1:0] n_end;
    logic       has_byte;
    logic [7:0] data;
    logic       fin;
  } lec_cmd_t;

endpackage

// ----- src/lec_front.sv -----
module lec_front import lec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  output logic       push_o,
  output lec_cmd_t   cmd_o,
  input  logic       full_i
);

  logic cr_pending_q, cr_pending_d;
  logic accept;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.data     = in_byte_i;
    cmd_o.fin      = in_final_i;
    cmd_o.n_end    = {1'b0, cr_pending_q};
    cr_pending_d   = cr_pending_q;
    if (accept) begin
      cr_pending_d = 1'b0;
      // an LF right after a held CR only completes the pair
      if (!(cr_pending_q && in_byte_i == CharLf)) begin
        if (in_byte_i == CharCr) begin
          if (in_final_i) begin
            cmd_o.n_end = cmd_o.n_end + 2'd1;
          end else begin
            cr_pending_d = 1'b1;
          end
        end else if (in_byte_i == CharLf) begin
          cmd_o.n_end = cmd_o.n_end + 2'd1;
        end else begin
          cmd_o.has_byte = 1'b1;
        end
      end
    end
  end

  // a held CR with nothing pending yields no output, so nothing is queued
  assign push_o = accept & ((cmd_o.n_end != 2'd0) | cmd_o.has_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_pending_q <= 1'b0;
    end else begin
      cr_pending_q <= cr_pending_d;
    end
  end

endmodule

// ----- src/lec_fifo.sv -----
module lec_fifo import lec_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lec_cmd_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output lec_cmd_t rdata_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  lec_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/lec_back.sv -----
module lec_back import lec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  lec_cmd_t   cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_end_o
);

  logic [1:0] pos_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, end_q;

  logic       two_byte;
  logic [2:0] end_cnt, total, pos_next;
  logic       load, is_last;
  logic [7:0] sel_byte;

  assign two_byte = (mode_i != ModeLf) && (mode_i != ModeCr);
  assign end_cnt  = two_byte ? {cmd_i.n_end, 1'b0} : {1'b0, cmd_i.n_end};
  assign total    = end_cnt + {2'b00, cmd_i.has_byte};
  assign pos_next = {1'b0, pos_q} + 3'd1;
  assign is_last  = (pos_next == total);
  assign load     = ~empty_i & (~valid_q | out_ready_i);
  assign pop_o    = load & is_last;

  always_comb begin
    if ({1'b0, pos_q} < end_cnt) begin
      if (two_byte) begin
        sel_byte = pos_q[0] ? CharLf : CharCr;
      end else begin
        sel_byte = (mode_i == ModeLf) ? CharLf : CharCr;
      end
    end else begin
      sel_byte = cmd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_q   <= is_last ? 2'd0 : pos_next[1:0];
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      last_q <= is_last;
      end_q  <= is_last & cmd_i.fin;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = last_q;
  assign stream_end_o = end_q;

endmodule

// ----- src/line_ending_converter_core.sv -----
// Line ending converter: rewrites CR LF, lone CR and lone LF to the chosen form.
// Path: an accepted request is written into the queue, then its bytes are registered in the output register.
// Throughput: one input request per cycle while the queue is not full; output one byte per
//   cycle while the receiver is ready. An input yields 0 to 4 bytes (2 for a line ending in CR LF mode).
// Reset (rst_ni low, async): no CR held, queue and output register empty, mode CR LF.
module line_ending_converter_core import lec_pkg::*; #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: newline_mode, always ready
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // final_byte
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] stream_end
);

  logic [1:0] mode_q;
  lec_cmd_t   push_cmd, head_cmd;
  logic       push, full, pop, empty;

  // the user must rewrite mode only while idle (the block does not enforce it), so the back end reads it live
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCrLf;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // front: tracks the held CR and turns each byte into an endings+byte request, except a CR it holds back
  lec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  // short request queue decoupling the two sides
  lec_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (empty)
  );

  // back: expands each request into bytes, one per cycle while the receiver is ready, into the output register
  lec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .cmd_i        (head_cmd),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .run_last_o   (m_axis_tlast),
    .stream_end_o (m_axis_tuser)
  );

endmodule

// ----- tb/tb_line_ending_converter_core.sv -----
`timescale 1ns / 100ps

module tb_line_ending_converter_core;
  import lec_pkg::*;

  localparam logic [1:0] ModeSpare   = 2'd3;   // unused code, acts as CR LF
  localparam int         CycleLimit  = 200000;
  localparam int         DrainCycles = 8;
  localparam int         NumPhases   = 6;
  localparam int         PhaseItems  = 57;
  localparam int         NumRows     = 19;

  // one converted byte as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } out_byte_t;

  // directed row: fixed = 1 means the bytes in fix are what must come out
  typedef struct packed {
    logic [7:0]      data;
    logic            fin;
    logic            fixed;
    logic [2:0]      n_fix;
    logic [3:0][7:0] fix;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  // predictor state
  logic [1:0] nl_mode = ModeCrLf;
  logic       cr_held = 1'b0;

  out_byte_t  expected_q[$];
  int         err_count = 0;
  int         cycle_cnt = 0;
  dir_row_t   dir_rows[NumRows];

  line_ending_converter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [7:0] in_byte
    .s_axis_tlast  (s_axis_tlast),    // final_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast),    // run_last
    .m_axis_tuser  (m_axis_tuser)     // [0] stream_end
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  // append one line ending in the current target form
  function automatic void add_ending(inout logic [3:0][7:0] seq, inout int n);
    case (nl_mode)
      ModeLf: begin
        seq[n] = CharLf;
        n++;
      end
      ModeCr: begin
        seq[n] = CharCr;
        n++;
      end
      default: begin
        seq[n] = CharCr;
        seq[n + 1] = CharLf;
        n += 2;
      end
    endcase
  endfunction

  // bytes one request turns into; updates the held-CR flag
  function automatic int convert_byte(input logic [7:0] b, input logic fin,
                                      output logic [3:0][7:0] seq);
    int   n;
    logic pair;
    n = 0;
    pair = 1'b0;
    seq = '0;
    if (cr_held) begin
      cr_held = 1'b0;
      add_ending(seq, n);
      pair = (b == CharLf);   // LF completes the held CR
    end
    if (!pair) begin
      if (b == CharCr) begin
        if (fin) add_ending(seq, n);
        else cr_held = 1'b1;
      end else if (b == CharLf) begin
        add_ending(seq, n);
      end else begin
        seq[n] = b;
        n++;
      end
    end
    return n;
  endfunction

  // drive one request, wait for it to be taken, then queue what it should yield
  task automatic send_request(input logic [7:0] b, input logic fin, input logic fixed,
                              input int n_fix, input logic [3:0][7:0] fix);
    logic [3:0][7:0] seq;
    int              n;
    out_byte_t       res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    n = convert_byte(b, fin, seq);
    if (fixed) begin
      n = n_fix;
      seq = fix;
    end
    for (int i = 0; i < n; i++) begin
      res.data       = seq[i];
      res.run_last   = (i == n - 1);
      res.stream_end = fin && (i == n - 1);
      expected_q.push_back(res);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    nl_mode = m;
  endtask

  // random byte, weighted toward CR and LF so line endings stay dense
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return CharCr;
    if (r < 40) return CharLf;
    if (r < 48) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: picks a stall style and holds it for a random stretch
  int unsigned stall_style = 0;
  int unsigned stall_left  = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 1) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (cycle_cnt % 3 != 0);
    endcase
  end

  // output checker
  always @(posedge clk_i) begin
    out_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.data));
        if (m_axis_tlast !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b", m_axis_tlast, want.run_last));
        if (m_axis_tuser !== want.stream_end)
          report_mismatch($sformatf("stream_end %b, want %b", m_axis_tuser,
                                    want.stream_end));
      end
    end
  end

  initial begin
    logic [1:0] phase_modes[NumPhases];
    int         burst_left;
    int         gap;
    logic       fin;

    // reset mode is CR LF; fix holds bytes first-out in the low byte
    dir_rows[0]  = '{8'h41, 1'b0, 1'b1, 3'd1, 32'h0000_0041};
    dir_rows[1]  = '{8'h00, 1'b0, 1'b1, 3'd1, 32'h0000_0000};
    dir_rows[2]  = '{8'hFF, 1'b0, 1'b1, 3'd1, 32'h0000_00FF};
    dir_rows[3]  = '{8'h80, 1'b0, 1'b0, 3'd0, 32'h0};
    dir_rows[4]  = '{8'h7F, 1'b0, 1'b0, 3'd0, 32'h0};
    dir_rows[5]  = '{CharLf, 1'b0, 1'b1, 3'd2, 32'h0000_0A0D};  // lone LF
    dir_rows[6]  = '{CharCr, 1'b0, 1'b1, 3'd0, 32'h0};          // CR held
    dir_rows[7]  = '{CharLf, 1'b0, 1'b1, 3'd2, 32'h0000_0A0D};  // CR LF pair
    dir_rows[8]  = '{CharCr, 1'b0, 1'b1, 3'd0, 32'h0};
    dir_rows[9]  = '{CharCr, 1'b0, 1'b1, 3'd2, 32'h0000_0A0D};  // CR then CR
    dir_rows[10] = '{8'h5A, 1'b0, 1'b1, 3'd3, 32'h005A_0A0D};   // CR then data
    dir_rows[11] = '{CharCr, 1'b0, 1'b1, 3'd0, 32'h0};
    dir_rows[12] = '{CharCr, 1'b1, 1'b1, 3'd4, 32'h0A0D_0A0D};  // held CR + final CR
    dir_rows[13] = '{CharCr, 1'b1, 1'b1, 3'd2, 32'h0000_0A0D};  // final CR alone
    dir_rows[14] = '{CharLf, 1'b1, 1'b1, 3'd2, 32'h0000_0A0D};
    dir_rows[15] = '{8'hAA, 1'b0, 1'b0, 3'd0, 32'h0};
    dir_rows[16] = '{CharCr, 1'b0, 1'b1, 3'd0, 32'h0};
    dir_rows[17] = '{CharLf, 1'b1, 1'b1, 3'd2, 32'h0000_0A0D};  // pair ends stream
    dir_rows[18] = '{8'h55, 1'b1, 1'b1, 3'd1, 32'h0000_0055};

    phase_modes = '{ModeLf, ModeCr, ModeSpare, ModeCrLf, ModeCr, ModeLf};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].fixed,
                   dir_rows[i].n_fix, dir_rows[i].fix);
    end

    // every phase ends on a final byte, so no CR is held across a mode change
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_mode(phase_modes[p]);
      burst_left = 0;
      for (int k = 0; k < PhaseItems; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;
        fin = (k == PhaseItems - 1) || ($urandom_range(0, 29) == 0);
        send_request(pick_byte(), fin, 1'b0, 0, '0);
      end
    end

    wait_drained();
    if (expected_q.size() != 0) report_mismatch("bytes still expected at end");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lec_pkg.sv
src/lec_front.sv
src/lec_fifo.sv
src/lec_back.sv
src/line_ending_converter_core.sv
tb/tb_line_ending_converter_core.sv
